// ----- src/pfl_pkg.sv -----
package pfl_pkg;

  // Sizing
  localparam int NUM_FRAMES = 1024;
  localparam int NUM_LISTS  = 4;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int LIST_W     = $clog2(NUM_LISTS);
  localparam int TAG_W      = $clog2(NUM_LISTS + 1);
  localparam int SIZE_W     = $clog2(NUM_FRAMES + 1);
  localparam int SUM_W      = SIZE_W + 2;
  localparam int ALU_W      = SUM_W;

  // Field widths of the channels
  localparam int ACTION_W  = 2;
  localparam int LIST_ID_W = 2;
  localparam int FIDX_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // List codes
  localparam logic [TAG_W-1:0]  NO_LIST         = TAG_W'(NUM_LISTS);
  localparam logic [LIST_W-1:0] LIST_MODIFIED   = LIST_W'(3);
  localparam logic [LIST_W-1:0] LIST_LAST_AVAIL = LIST_W'(2);

  // Register reset values
  localparam logic [CFG_W-1:0] THR_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] MIN_RST = CFG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD_THR   = 1'd0,
    CFG_MIN_AVAIL = 1'd1
  } cfg_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT    = 2'd0,
    ACT_REM_HEAD  = 2'd1,
    ACT_REM_TAIL  = 2'd2,
    ACT_REM_NAMED = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_MISUSE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_CMP
  } alu_op_t;

  // Frame store access: one write per array, one shared read address
  typedef struct packed {
    logic [FRAME_W-1:0] raddr;
    logic               next_we;
    logic [FRAME_W-1:0] next_waddr;
    logic [FRAME_W-1:0] next_wdata;
    logic               prev_we;
    logic [FRAME_W-1:0] prev_waddr;
    logic [FRAME_W-1:0] prev_wdata;
    logic               tag_we;
    logic [FRAME_W-1:0] tag_waddr;
    logic [TAG_W-1:0]   tag_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] next_q;
    logic [FRAME_W-1:0] prev_q;
    logic [TAG_W-1:0]   tag_q;
  } mem_rsp_t;

endpackage

// ----- src/pfl_if.sv -----
interface pfl_in_if import pfl_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [LIST_ID_W-1:0] list_id;
  logic [FIDX_W-1:0]    frame_index;

  modport source (output valid, action, list_id, frame_index, input ready);
  modport sink   (input valid, action, list_id, frame_index, output ready);
endinterface

interface pfl_out_if import pfl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIDX_W-1:0]   removed_frame;
  logic [COUNT_W-1:0]  list_count;
  logic                wake_writer;
  logic                wake_trimmer;

  modport source (output valid, status, removed_frame, list_count, wake_writer,
                  wake_trimmer, input ready);
  modport sink   (input valid, status, removed_frame, list_count, wake_writer,
                  wake_trimmer, output ready);
endinterface

interface pfl_cfg_if import pfl_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/page_frame_list_manager_top.sv -----
// Channel   Direction  Payload
// in_ch     sink       action, list_id, frame_index
// out_ch    source     status, removed_frame, list_count, wake_writer, wake_trimmer
// cfg_ch    sink       index (0 modified wake threshold, 1 min available), data
//
// An item runs in steps: the transfer cycle launches the registered frame
// store read, a second step relinks and updates the count, and a last step
// writes the last link, runs the wake compare on the shared ALU and loads the
// result. After reset the tag store is swept over all NUM_FRAMES (1024) frames;
// in_ch is not ready meanwhile, cfg_ch always is. A stalled out_ch
// holds the block in its last step until the output register frees.
module page_frame_list_manager_top import pfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pfl_in_if.sink    in_ch,
  pfl_out_if.source out_ch,
  pfl_cfg_if.sink   cfg_ch
);

  mem_req_t         mreq;
  mem_rsp_t         mrsp;
  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_y;
  logic             alu_lt;

  pfl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .mreq   (mreq),
    .mrsp   (mrsp),
    .alu_op (alu_op),
    .alu_a  (alu_a),
    .alu_b  (alu_b),
    .alu_y  (alu_y),
    .alu_lt (alu_lt)
  );

  pfl_frame_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  pfl_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .lt (alu_lt)
  );

endmodule

// ----- src/pfl_frame_mem.sv -----
module pfl_frame_mem import pfl_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [FRAME_W-1:0] next_mem [NUM_FRAMES];
  logic [FRAME_W-1:0] prev_mem [NUM_FRAMES];
  logic [TAG_W-1:0]   tag_mem  [NUM_FRAMES];

  // Write each array at its own address, read all three at one address
  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_waddr] <= req.next_wdata;
    end
    if (req.prev_we) begin
      prev_mem[req.prev_waddr] <= req.prev_wdata;
    end
    if (req.tag_we) begin
      tag_mem[req.tag_waddr] <= req.tag_wdata;
    end
    rsp.next_q <= next_mem[req.raddr];
    rsp.prev_q <= prev_mem[req.raddr];
    rsp.tag_q  <= tag_mem[req.raddr];
  end

endmodule

// ----- src/pfl_alu.sv -----
module pfl_alu import pfl_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] y,
  output logic             lt
);

  // Shared count update and compare
  always_comb begin
    lt = (a < b);
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_CMP: y = '0;
      default: y = '0;
    endcase
  end

endmodule

// ----- src/pfl_ctrl.sv -----
module pfl_ctrl import pfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pfl_in_if.sink    in_ch,
  pfl_out_if.source out_ch,
  pfl_cfg_if.sink   cfg_ch,
  output mem_req_t  mreq,
  input  mem_rsp_t  mrsp,
  output alu_op_t   alu_op,
  output logic [ALU_W-1:0] alu_a,
  output logic [ALU_W-1:0] alu_b,
  input  logic [ALU_W-1:0] alu_y,
  input  logic             alu_lt
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RES
  } state_t;

  typedef enum logic [2:0] {
    RK_INS_OK,
    RK_REM_OK,
    RK_EMPTY,
    RK_MISUSE_INS,
    RK_MISUSE_REM
  } res_kind_t;

  state_t             state_r, state_nxt;
  res_kind_t          kind_r, kind_nxt;
  action_t            act_r, act_nxt;
  logic [LIST_W-1:0]  lst_r, lst_nxt;
  logic [FRAME_W-1:0] frm_r, frm_nxt;
  logic               fok_r, fok_nxt;
  logic               pend_r, pend_nxt;
  logic [FRAME_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [FRAME_W-1:0] clr_r, clr_nxt;
  logic [FRAME_W-1:0] head_r [NUM_LISTS];
  logic [FRAME_W-1:0] head_nxt [NUM_LISTS];
  logic [FRAME_W-1:0] tail_r [NUM_LISTS];
  logic [FRAME_W-1:0] tail_nxt [NUM_LISTS];
  logic [SIZE_W-1:0]  size_r [NUM_LISTS];
  logic [SIZE_W-1:0]  size_nxt [NUM_LISTS];
  logic [CFG_W-1:0]   thr_r, thr_nxt;
  logic [CFG_W-1:0]   min_r, min_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [FIDX_W-1:0]   removed_r, removed_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                wakew_r, wakew_nxt;
  logic                waket_r, waket_nxt;

  logic [LIST_W-1:0]  in_lst;
  logic [LIST_W-1:0]  el;
  logic               do_unlink;
  logic [FRAME_W-1:0] nx, pv;
  logic [SIZE_W-1:0]  cnt;
  logic [SUM_W-1:0]   avail_sum;
  logic               out_free;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.removed_frame = removed_r;
  assign out_ch.list_count    = count_r;
  assign out_ch.wake_writer   = wakew_r;
  assign out_ch.wake_trimmer  = waket_r;

  assign in_lst    = LIST_W'(in_ch.list_id);
  assign el        = (act_r == ACT_REM_NAMED) ? LIST_W'(mrsp.tag_q) : lst_r;
  assign nx        = mrsp.next_q;
  assign pv        = mrsp.prev_q;
  assign cnt       = size_r[lst_r];
  assign avail_sum = SUM_W'(size_r[0]) + SUM_W'(size_r[1]) + SUM_W'(size_r[2]);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    act_nxt       = act_r;
    lst_nxt       = lst_r;
    frm_nxt       = frm_r;
    fok_nxt       = fok_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    size_nxt      = size_r;
    thr_nxt       = thr_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    count_nxt     = count_r;
    wakew_nxt     = wakew_r;
    waket_nxt     = waket_r;
    do_unlink     = 1'b0;

    mreq            = '0;
    mreq.raddr      = frm_r;
    alu_op          = ALU_CMP;
    alu_a           = '0;
    alu_b           = '0;

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_MOD_THR:   thr_nxt = cfg_ch.data;
        CFG_MIN_AVAIL: min_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    case (state_r)
      // Sweep the tag store to "on no list"
      S_CLEAR: begin
        mreq.tag_we    = 1'b1;
        mreq.tag_waddr = clr_r;
        mreq.tag_wdata = NO_LIST;
        clr_nxt        = clr_r + 1'b1;
        if (clr_r == FRAME_W'(NUM_FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take an item and read the links and tag of its target frame
      S_IDLE: begin
        case (action_t'(in_ch.action))
          ACT_REM_HEAD: frm_nxt = head_r[in_lst];
          ACT_REM_TAIL: frm_nxt = tail_r[in_lst];
          default:      frm_nxt = FRAME_W'(in_ch.frame_index);
        endcase
        mreq.raddr = frm_nxt;
        if (in_ch.valid) begin
          act_nxt   = action_t'(in_ch.action);
          lst_nxt   = in_lst;
          fok_nxt   = (32'(in_ch.frame_index) < 32'(NUM_FRAMES));
          state_nxt = S_EVAL;
        end
      end

      // Relink and update head, tail and count
      S_EVAL: begin
        pend_nxt  = 1'b0;
        state_nxt = S_RES;
        case (act_r)
          ACT_INSERT: begin
            if (!fok_r || mrsp.tag_q != NO_LIST) begin
              kind_nxt = RK_MISUSE_INS;
            end else begin
              kind_nxt        = RK_INS_OK;
              mreq.next_we    = 1'b1;
              mreq.next_waddr = frm_r;
              mreq.next_wdata = head_r[lst_r];
              mreq.prev_we    = 1'b1;
              mreq.prev_waddr = frm_r;
              mreq.prev_wdata = '0;
              mreq.tag_we     = 1'b1;
              mreq.tag_waddr  = frm_r;
              mreq.tag_wdata  = TAG_W'(lst_r);
              pend_nxt        = (size_r[lst_r] != '0);
              pend_addr_nxt   = head_r[lst_r];
              if (size_r[lst_r] == '0) begin
                tail_nxt[lst_r] = frm_r;
              end
              head_nxt[lst_r] = frm_r;
              alu_op          = ALU_ADD;
              alu_a           = ALU_W'(size_r[lst_r]);
              alu_b           = ALU_W'(1);
              size_nxt[lst_r] = SIZE_W'(alu_y);
            end
          end
          ACT_REM_NAMED: begin
            if (!fok_r || mrsp.tag_q >= NO_LIST) begin
              kind_nxt = RK_MISUSE_REM;
            end else begin
              lst_nxt   = el;
              do_unlink = 1'b1;
            end
          end
          default: begin
            if (size_r[lst_r] == '0) begin
              kind_nxt = RK_EMPTY;
            end else begin
              do_unlink = 1'b1;
            end
          end
        endcase

        // Take the target off list el
        if (do_unlink) begin
          kind_nxt = RK_REM_OK;
          if (head_r[el] == frm_r) begin
            head_nxt[el] = nx;
          end else begin
            mreq.next_we    = 1'b1;
            mreq.next_waddr = pv;
            mreq.next_wdata = nx;
          end
          if (tail_r[el] == frm_r) begin
            tail_nxt[el] = pv;
          end else begin
            mreq.prev_we    = 1'b1;
            mreq.prev_waddr = nx;
            mreq.prev_wdata = pv;
          end
          mreq.tag_we    = 1'b1;
          mreq.tag_waddr = frm_r;
          mreq.tag_wdata = NO_LIST;
          alu_op         = ALU_SUB;
          alu_a          = ALU_W'(size_r[el]);
          alu_b          = ALU_W'(1);
          size_nxt[el]   = SIZE_W'(alu_y);
        end
      end

      // Finish the old head's back link, raise wake flags, load the result
      S_RES: begin
        if (pend_r) begin
          mreq.prev_we    = 1'b1;
          mreq.prev_waddr = pend_addr_r;
          mreq.prev_wdata = frm_r;
        end
        alu_op = ALU_CMP;
        if (kind_r == RK_INS_OK) begin
          alu_a = ALU_W'(thr_r);
          alu_b = ALU_W'(cnt);
        end else begin
          alu_a = ALU_W'(avail_sum);
          alu_b = ALU_W'(min_r);
        end
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          removed_nxt   = '0;
          count_nxt     = '0;
          wakew_nxt     = 1'b0;
          waket_nxt     = 1'b0;
          case (kind_r)
            RK_INS_OK: begin
              status_nxt = ST_DONE;
              count_nxt  = COUNT_W'(cnt);
              wakew_nxt  = (lst_r == LIST_MODIFIED) && alu_lt;
            end
            RK_REM_OK: begin
              status_nxt  = ST_DONE;
              count_nxt   = COUNT_W'(cnt);
              removed_nxt = FIDX_W'(frm_r);
              waket_nxt   = (lst_r <= LIST_LAST_AVAIL) && alu_lt;
            end
            RK_EMPTY: begin
              status_nxt = ST_EMPTY;
            end
            RK_MISUSE_INS: begin
              status_nxt = ST_MISUSE;
              count_nxt  = COUNT_W'(cnt);
            end
            default: begin
              status_nxt = ST_MISUSE;
            end
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, list registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      thr_r       <= THR_RST;
      min_r       <= MIN_RST;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        size_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      thr_r       <= thr_nxt;
      min_r       <= min_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      size_r      <= size_nxt;
    end
    kind_r      <= kind_nxt;
    act_r       <= act_nxt;
    lst_r       <= lst_nxt;
    frm_r       <= frm_nxt;
    fok_r       <= fok_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    removed_r   <= removed_nxt;
    count_r     <= count_nxt;
    wakew_r     <= wakew_nxt;
    waket_r     <= waket_nxt;
  end

endmodule

// ----- src/pfl_checker.sv -----
module pfl_checker import pfl_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [FIDX_W-1:0]   removed_frame,
  input logic [COUNT_W-1:0]  list_count,
  input logic                wake_writer,
  input logic                wake_trimmer
);

  // One item at a time: no back-to-back input transfers
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // Empty list result carries nothing
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |->
      removed_frame == '0 && list_count == '0 && !wake_writer && !wake_trimmer)
    else $error("empty-list result with payload");

  // Misuse removes nothing and wakes nobody
  a_misuse_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_MISUSE |->
      removed_frame == '0 && !wake_writer && !wake_trimmer)
    else $error("misuse result with payload");

  // Writer wake only on a result with done status, never with trimmer wake
  a_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wake_writer |-> status == ST_DONE && !wake_trimmer)
    else $error("writer wake on a result that is not a clean insert");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(removed_frame) && $stable(list_count))
    else $error("stalled result changed");

endmodule

bind page_frame_list_manager_top pfl_checker u_pfl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .removed_frame (out_ch.removed_frame),
  .list_count    (out_ch.list_count),
  .wake_writer   (out_ch.wake_writer),
  .wake_trimmer  (out_ch.wake_trimmer)
);
